// ===== design/plc_pkg.sv =====
package plc_pkg;

    localparam int unsigned ID_SLOTS_DEF = 64;

    localparam int unsigned CNT_W   = 31;
    localparam int unsigned ID_W    = 6;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = 31'h7FFF_FFFF;

    localparam logic [CNT_W-1:0] HIGH_WM_RST = 31'd2500;
    localparam logic [CNT_W-1:0] LOW_WM_RST  = 31'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_ENABLE    = 2'd0,
        CFG_HIGH_WATERMARK  = 2'd1,
        CFG_LOW_WATERMARK   = 2'd2,
        CFG_THROTTLE_CREATE = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        FUNC_CREATE  = 1'b0,
        FUNC_DESTROY = 1'b1
    } t_func;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] caller_id;
        logic            was_tracked;
    } t_in_beat;

    typedef struct packed {
        logic             allowed;
        logic             tracked;
        logic             notify_limit;
        logic             underflow;
        logic [CNT_W-1:0] count_after;
        logic             limit_flag;
    } t_out_beat;

    typedef struct packed {
        logic             count_enable;
        logic [CNT_W-1:0] high_watermark;
        logic [CNT_W-1:0] low_watermark;
        logic             throttle_create;
    } t_cfg;

    typedef struct packed {
        logic             flag;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] last_notice;
    } t_slot;

    typedef struct packed {
        t_in_beat req;
        logic     in_range;
    } t_s1_req;

endpackage

// ===== design/plc_store.sv =====
module plc_store
    import plc_pkg::*;
#(
    parameter int unsigned ID_SLOTS = ID_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(ID_SLOTS)-1:0] i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [$clog2(ID_SLOTS)-1:0] i_wr_addr,
    input  t_slot                       i_wr_data,
    output t_slot                       o_rd_data
);

    t_slot               r_mem [ID_SLOTS];
    logic [ID_SLOTS-1:0] r_vld;
    t_slot               r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // write-through so a back-to-back beat to the same slot sees the update
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else if (r_vld[i_rd_addr]) begin
                r_rd <= r_mem[i_rd_addr];
            end else begin
                r_rd <= '0;
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

// ===== design/plc_calc.sv =====
module plc_calc
    import plc_pkg::*;
(
    input  t_s1_req   i_req,
    input  t_slot     i_entry,
    input  t_cfg      i_cfg,
    output t_slot     o_entry,
    output t_out_beat o_res
);

    logic             refuse;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] last;
    logic [CNT_W-1:0] gap;

    assign cnt  = i_entry.count;
    assign last = i_entry.last_notice;
    assign gap  = cnt - last;

    always_comb begin
        o_entry            = i_entry;
        o_res              = '0;
        o_res.allowed      = 1'b1;
        refuse             = 1'b0;

        if (i_req.in_range) begin
            if (i_req.req.func == FUNC_CREATE) begin
                if (i_cfg.count_enable) begin
                    if (i_entry.flag) begin
                        if (i_cfg.throttle_create) begin
                            refuse        = 1'b1;
                            o_res.allowed = 1'b0;
                        end else if ((cnt > last) && (gap > i_cfg.high_watermark)) begin
                            o_res.notify_limit  = 1'b1;
                            o_entry.last_notice = cnt;
                        end
                    end else if (cnt >= i_cfg.high_watermark) begin
                        o_entry.flag        = 1'b1;
                        o_entry.last_notice = cnt;
                        o_res.notify_limit  = 1'b1;
                        o_res.tracked       = 1'b1;
                        if (i_cfg.throttle_create) begin
                            refuse        = 1'b1;
                            o_res.allowed = 1'b0;
                        end
                    end
                    if (!refuse) begin
                        if (cnt != CNT_MAX) begin
                            o_entry.count = cnt + 1'b1;
                        end
                        o_res.tracked = 1'b1;
                    end
                end
            end else if (i_req.req.was_tracked) begin
                if (cnt == '0) begin
                    o_res.underflow = 1'b1;
                end else begin
                    if (i_entry.flag && (cnt <= i_cfg.low_watermark)) begin
                        o_entry.flag        = 1'b0;
                        o_entry.last_notice = '0;
                    end
                    o_entry.count = cnt - 1'b1;
                    o_res.tracked = 1'b1;
                end
            end
            o_res.count_after = o_entry.count;
            o_res.limit_flag  = o_entry.flag;
        end
    end

endmodule

// ===== design/per_id_count_watermark_limiter.sv =====
// Pipeline: an accepted beat and its slot read register in stage s1; the result register
// loads from s1 when the output is free. Throughput: one beat per cycle unless the output
// stalls; slot read on accept, write from update stage s1, with write-through to next read.
// Reset (synchronous, active low): pipeline empty, registers to defaults,
// slot valid bits cleared at once so every slot reads as zero; no sweep.
module per_id_count_watermark_limiter
    import plc_pkg::*;
#(
    parameter int unsigned ID_SLOTS = ID_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_beat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_wdata
);

    localparam int unsigned ADDR_W = $clog2(ID_SLOTS);

    t_cfg              r_cfg;
    logic              r_s1_valid;
    t_s1_req           r_s1_req;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_out_valid;
    t_out_beat         r_out_beat;

    logic              out_free;
    logic              s1_adv;
    logic              in_acc;
    logic [31:0]       id_ext;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;
    t_slot             rd_entry;
    t_slot             n_entry;
    t_out_beat         n_out_beat;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = !i_rst_n || (r_s1_valid && !out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign id_ext   = 32'(i_in_beat.caller_id);
    assign in_addr  = id_ext[ADDR_W-1:0];
    assign in_range = (id_ext < 32'(ID_SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_enable    <= 1'b0;
            r_cfg.high_watermark  <= HIGH_WM_RST;
            r_cfg.low_watermark   <= LOW_WM_RST;
            r_cfg.throttle_create <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COUNT_ENABLE:    r_cfg.count_enable    <= i_cfg_wdata[0];
                CFG_HIGH_WATERMARK:  r_cfg.high_watermark  <= i_cfg_wdata;
                CFG_LOW_WATERMARK:   r_cfg.low_watermark   <= i_cfg_wdata;
                CFG_THROTTLE_CREATE: r_cfg.throttle_create <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req.req      <= i_in_beat;
            r_s1_req.in_range <= in_range;
            r_s1_addr         <= in_addr;
        end
        if (s1_adv) begin
            r_out_beat <= n_out_beat;
        end
    end

    plc_store #(
        .ID_SLOTS (ID_SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_addr),
        .i_wr_en   (s1_adv && r_s1_req.in_range),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (n_entry),
        .o_rd_data (rd_entry)
    );

    plc_calc u_calc (
        .i_req   (r_s1_req),
        .i_entry (rd_entry),
        .i_cfg   (r_cfg),
        .o_entry (n_entry),
        .o_res   (n_out_beat)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ===== design/plc_chk.sv =====
module plc_chk
    import plc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_beat            o_out_beat
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled result beat changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.underflow |->
            !o_out_beat.tracked && o_out_beat.allowed && (o_out_beat.count_after == '0))
        else $error("underflow beat with changed slot");

    a_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.notify_limit |->
            o_out_beat.limit_flag && o_out_beat.tracked)
        else $error("notice without limit flag");

    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.allowed |-> o_out_beat.limit_flag)
        else $error("create refused without limit flag");

endmodule

bind per_id_count_watermark_limiter plc_chk u_plc_chk (.*);

// ===== verif/limit_count_checker.sv =====
`timescale 1ns / 100ps

module limit_count_checker
    import plc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_beat             i_in_beat,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_beat            i_out_beat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic             slot_flag   [ID_SLOTS_DEF];
    logic [CNT_W-1:0] slot_count  [ID_SLOTS_DEF];
    logic [CNT_W-1:0] slot_notice [ID_SLOTS_DEF];
    t_cfg             cfg;
    t_out_beat        expected_q[$];
    int               errors = 0;

    assign o_fail_count = errors;

    function automatic t_out_beat limit_step(t_in_beat b);
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] last;
        logic             flag;
        logic             refuse;
        t_out_beat        r;
        id     = b.caller_id;
        cnt    = slot_count[id];
        flag   = slot_flag[id];
        refuse = 1'b0;
        r      = '0;
        r.allowed = 1'b1;
        if (b.func == FUNC_CREATE) begin
            if (cfg.count_enable) begin
                if (flag) begin
                    if (cfg.throttle_create) begin
                        refuse    = 1'b1;
                        r.allowed = 1'b0;
                    end else begin
                        last = slot_notice[id];
                        if (cnt > last && (cnt - last) > cfg.high_watermark) begin
                            r.notify_limit  = 1'b1;
                            slot_notice[id] = cnt;
                        end
                    end
                end else if (cnt >= cfg.high_watermark) begin
                    flag            = 1'b1;
                    r.notify_limit  = 1'b1;
                    r.tracked       = 1'b1;
                    slot_notice[id] = cnt;
                    if (cfg.throttle_create) begin
                        refuse    = 1'b1;
                        r.allowed = 1'b0;
                    end
                end
                if (!refuse) begin
                    if (cnt != CNT_MAX) cnt = cnt + 1'b1;
                    r.tracked = 1'b1;
                end
                slot_count[id] = cnt;
                slot_flag[id]  = flag;
            end
        end else if (b.was_tracked) begin
            if (cnt == '0) begin
                r.underflow = 1'b1;
            end else begin
                if (flag && cnt <= cfg.low_watermark) begin
                    flag            = 1'b0;
                    slot_notice[id] = '0;
                end
                slot_count[id] = cnt - 1'b1;
                slot_flag[id]  = flag;
                r.tracked      = 1'b1;
            end
        end
        r.count_after = slot_count[id];
        r.limit_flag  = slot_flag[id];
        return r;
    endfunction

    task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < ID_SLOTS_DEF; i++) begin
                slot_flag[i]   = 1'b0;
                slot_count[i]  = '0;
                slot_notice[i] = '0;
            end
            cfg.count_enable    = 1'b0;
            cfg.high_watermark  = HIGH_WM_RST;
            cfg.low_watermark   = LOW_WM_RST;
            cfg.throttle_create = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COUNT_ENABLE:    cfg.count_enable    = i_cfg_wdata[0];
                    CFG_HIGH_WATERMARK:  cfg.high_watermark  = i_cfg_wdata;
                    CFG_LOW_WATERMARK:   cfg.low_watermark   = i_cfg_wdata;
                    CFG_THROTTLE_CREATE: cfg.throttle_create = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("allowed", CNT_W'(want.allowed),
                                CNT_W'(i_out_beat.allowed));
                    check_field("tracked", CNT_W'(want.tracked),
                                CNT_W'(i_out_beat.tracked));
                    check_field("notify_limit", CNT_W'(want.notify_limit),
                                CNT_W'(i_out_beat.notify_limit));
                    check_field("underflow", CNT_W'(want.underflow),
                                CNT_W'(i_out_beat.underflow));
                    check_field("count_after", want.count_after, i_out_beat.count_after);
                    check_field("limit_flag", CNT_W'(want.limit_flag),
                                CNT_W'(i_out_beat.limit_flag));
                end
            end
            if (i_in_valid && !i_in_stall) expected_q.push_back(limit_step(i_in_beat));
        end
        o_pending <= expected_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import plc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_PAD      = 4;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_BEATS    = 75;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_beat             i_in_beat   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_beat            o_out_beat;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CNT_W-1:0]     i_cfg_wdata = '0;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   gaps_on     = 1'b1;
    int   create_pct  = 60;
    logic press_req   = 1'b0;
    bit   press_done  = 1'b0;

    per_id_count_watermark_limiter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    limit_count_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_beat    (i_in_beat),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_beat   (o_out_beat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_beat(t_in_beat b);
        int gap;
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_op(t_func f, int id, bit trk);
        t_in_beat b;
        b.func        = f;
        b.caller_id   = ID_W'(id);
        b.was_tracked = trk;
        send_beat(b);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CNT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic set_config(bit en, logic [CNT_W-1:0] hi, logic [CNT_W-1:0] lo, bit thr);
        wait_drained();
        write_reg(CFG_COUNT_ENABLE, CNT_W'(en));
        write_reg(CFG_HIGH_WATERMARK, hi);
        write_reg(CFG_LOW_WATERMARK, lo);
        write_reg(CFG_THROTTLE_CREATE, CNT_W'(thr));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        b.func        = ($urandom_range(0, 99) < create_pct) ? FUNC_CREATE : FUNC_DESTROY;
        b.caller_id   = ID_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                         : $urandom_range(0, 63));
        b.was_tracked = ($urandom_range(0, 9) < 8);
        return b;
    endfunction

    // receiver: runs of free flow, random stalls, and one long hold-off on request
    initial begin
        int r;
        int len;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (press_req && !press_done) begin
                press_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    i_out_stall <= 1'b0;
                    len = $urandom_range(1, 20);
                end else if (r < 70) begin
                    i_out_stall <= 1'($urandom_range(0, 1));
                    len = $urandom_range(1, 3);
                end else if (r < 95) begin
                    i_out_stall <= 1'b1;
                    len = $urandom_range(4, 10);
                end else begin
                    i_out_stall <= 1'b1;
                    len = $urandom_range(20, 50);
                end
                repeat (len) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [CNT_W-1:0] hi;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // counting off at reset: creates pass untouched, destroys still act
        send_op(FUNC_CREATE, 0, 1'b1);
        send_op(FUNC_DESTROY, 63, 1'b0);
        send_op(FUNC_DESTROY, 5, 1'b1);

        // flag set, renotify after a further watermark, drain back to clear
        set_config(1'b1, CNT_W'(2), CNT_W'(1), 1'b0);
        repeat (7) send_op(FUNC_CREATE, 63, 1'b0);
        repeat (7) send_op(FUNC_DESTROY, 63, 1'b1);

        // throttled: refusal that sets the flag, then refusal with flag held
        set_config(1'b1, CNT_W'(2), CNT_W'(1), 1'b1);
        repeat (4) send_op(FUNC_CREATE, 1, 1'b1);
        send_op(FUNC_DESTROY, 1, 1'b0);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(1'b1, '0, '0, 1'b0);
                1: set_config(1'b1, CNT_MAX, CNT_MAX, 1'b1);
                2: set_config(1'b0, CNT_W'($urandom_range(0, 6)), CNT_W'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)));
                default: begin
                    hi = CNT_W'($urandom_range(1, 6));
                    set_config(1'b1, hi, CNT_W'($urandom_range(0, 32'(hi))),
                               1'($urandom_range(0, 1)));
                end
            endcase
            gaps_on    = (p % 3 != 1);
            create_pct = (p % 2 == 0) ? 65 : 45;
            if (p == 3) press_req <= 1'b1;
            repeat (PHASE_BEATS) send_beat(rand_beat());
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/plc_pkg.sv
design/plc_store.sv
design/plc_calc.sv
design/per_id_count_watermark_limiter.sv
design/plc_chk.sv
verif/limit_count_checker.sv
verif/testbench.sv
